@@ design/dbc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared widths, display slot codes and the item type passed from the front
// end to the display sequencer.
// ----------------------------------------------------------------------------
package dbc_pkg;

   // field widths of the channels
   localparam int LEVEL_WIDTH     = 8;
   localparam int SELECT_WIDTH    = 3;
   localparam int SEGMENT_WIDTH   = 8;
   localparam int COUNT_WIDTH     = 10;

   // default sizing
   localparam int NUM_BUTTONS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   // display slot codes, in scan order
   typedef logic [SELECT_WIDTH-1:0] slot_type;
   localparam slot_type SLOT_ONES      = 3'd0;
   localparam slot_type SLOT_TENS      = 3'd1;
   localparam slot_type SLOT_COLON     = 3'd2;
   localparam slot_type SLOT_HUNDREDS  = 3'd3;
   localparam slot_type SLOT_THOUSANDS = 3'd4;
   localparam slot_type SLOT_COUNT     = 3'd5;

   localparam logic [SEGMENT_WIDTH-1:0] BLANK_PATTERN = 8'hFF;

   // one classified tick: count, its decimal digits and how many slots to show
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic                   thousands;
      logic [3:0]             hundreds;
      logic [3:0]             tens;
      logic [3:0]             ones;
      slot_type               shown;
   } dbc_entry_type;

endpackage

@@ design/dbc_if.sv @@
// ----------------------------------------------------------------------------
// dbc_if
// Valid/ready channels for button ticks and display slot items.
// ----------------------------------------------------------------------------
interface dbc_req_if;
   import dbc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LEVEL_WIDTH-1:0] button_levels;

   modport source (output valid, output button_levels, input ready);
   modport sink   (input valid, input button_levels, output ready);
endinterface

interface dbc_rsp_if;
   import dbc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SELECT_WIDTH-1:0]  digit_select;
   logic [SEGMENT_WIDTH-1:0] segment_pattern;
   logic [COUNT_WIDTH-1:0]   count_value;
   logic                     last;

   modport source (output valid, output digit_select, output segment_pattern,
                   output count_value, output last, input ready);
   modport sink   (input valid, input digit_select, input segment_pattern,
                   input count_value, input last, output ready);
endinterface

@@ design/dbc_front.sv @@
// ----------------------------------------------------------------------------
// dbc_front
// Debounces the buttons and updates the count on each accepted tick, then
// splits the count into decimal digits and works out how many slots to show.
// ----------------------------------------------------------------------------
module dbc_front #(
   parameter int NUM_BUTTONS = dbc_pkg::NUM_BUTTONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   dbc_req_if.sink                req_ch,
   output dbc_pkg::dbc_entry_type push_entry,
   output logic                   push_valid,
   input  logic                   push_ready
);
   import dbc_pkg::*;

   localparam logic [15:0] HIST_FORCE  = 16'hE000;
   localparam logic [15:0] HIST_PRESS  = 16'hF000;
   localparam logic [10:0] COUNT_LIMIT = 11'd1023;

   logic [15:0]            hist_ff [NUM_BUTTONS];
   logic [15:0]            hist_in [NUM_BUTTONS];
   logic [15:0]            hist_next [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] press_mask;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [10:0]            sum;
   logic [10:0]            acc;
   logic                   wrap;
   logic                   accept;

   logic                   a_valid_ff, a_valid_in;
   logic [COUNT_WIDTH-1:0] a_count_ff, a_count_in;
   logic                   a_wrap_ff, a_wrap_in;

   slot_type               shown_ff, shown_in;
   slot_type               shown_base, shown_new;
   logic                   slot_nonzero;
   logic                   push;

   logic                   thou;
   logic [COUNT_WIDTH-1:0] rem1, rem2;
   logic [3:0]             hund, tens, ones;

   assign accept        = req_ch.valid && req_ch.ready;
   assign push          = a_valid_ff && push_ready;
   assign push_valid    = a_valid_ff;
   assign req_ch.ready  = !a_valid_ff || push_ready;

   // debounce each button and add up its presses
   // the presses of one tick sum to at most 255, so the count wraps at most once
   always_comb begin
      press_mask = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         hist_next[i]  = {hist_ff[i][14:0], req_ch.button_levels[i]} | HIST_FORCE;
         hist_in[i]    = accept ? hist_next[i] : hist_ff[i];
         press_mask[i] = (hist_next[i] == HIST_PRESS);
      end
      sum      = {1'b0, count_ff} + 11'(press_mask);
      wrap     = (sum > COUNT_LIMIT);
      acc      = wrap ? (sum - COUNT_LIMIT) : sum;
      count_in = accept ? acc[COUNT_WIDTH-1:0] : count_ff;
   end

   // stage register between counting and digit split
   always_comb begin
      a_valid_in = a_valid_ff;
      a_count_in = a_count_ff;
      a_wrap_in  = a_wrap_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_count_in = acc[COUNT_WIDTH-1:0];
         a_wrap_in  = wrap;
      end else if (push) begin
         a_valid_in = 1'b0;
      end
   end

   // decimal split by parallel threshold compares
   always_comb begin
      thou = (a_count_ff >= 10'd1000);
      rem1 = thou ? (a_count_ff - 10'd1000) : a_count_ff;
      hund = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem1 >= COUNT_WIDTH'(k * 100)) hund = 4'(k);
      end
      rem2 = rem1 - (COUNT_WIDTH'(hund) * 10'd100);
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem2 >= COUNT_WIDTH'(k * 10)) tens = 4'(k);
      end
      ones = rem2[3:0] - (tens[3:0] * 4'd10);
   end

   // shown-slot growth, restarted at one after a wrap
   always_comb begin
      shown_base = a_wrap_ff ? SLOT_TENS : shown_ff;
      case (shown_base)
         SLOT_ONES:      slot_nonzero = (ones != 4'd0);
         SLOT_TENS:      slot_nonzero = (tens != 4'd0);
         SLOT_COLON:     slot_nonzero = 1'b1;
         SLOT_HUNDREDS:  slot_nonzero = (hund != 4'd0);
         SLOT_THOUSANDS: slot_nonzero = thou;
         default:        slot_nonzero = 1'b0;
      endcase
      shown_new = (shown_base < SLOT_COUNT && slot_nonzero) ? shown_base + 3'd1 : shown_base;
      shown_in  = push ? shown_new : shown_ff;
   end

   // queued item
   always_comb begin
      push_entry.count     = a_count_ff;
      push_entry.thousands = thou;
      push_entry.hundreds  = hund;
      push_entry.tens      = tens;
      push_entry.ones      = ones;
      push_entry.shown     = (shown_new == SLOT_ONES) ? SLOT_TENS : shown_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) hist_ff[i] <= '0;
         count_ff   <= '0;
         shown_ff   <= SLOT_TENS;
         a_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_BUTTONS; i++) hist_ff[i] <= hist_in[i];
         count_ff   <= count_in;
         shown_ff   <= shown_in;
         a_valid_ff <= a_valid_in;
      end
      a_count_ff <= a_count_in;
      a_wrap_ff  <= a_wrap_in;
   end

   // shown-slot count stays between one and five
   assert property (@(posedge clock) disable iff (reset)
      shown_ff != SLOT_ONES && shown_ff <= SLOT_COUNT)
      else $error("shown slot count out of range");

   // count only moves on an accepted item
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count changed without an item");

endmodule

@@ design/dbc_queue.sv @@
// ----------------------------------------------------------------------------
// dbc_queue
// Small first-in first-out buffer of classified ticks between the front end
// and the display sequencer.
// ----------------------------------------------------------------------------
module dbc_queue #(
   parameter int DEPTH = dbc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbc_pkg::dbc_entry_type push_entry,
   input  logic                   push_valid,
   output logic                   push_ready,
   output dbc_pkg::dbc_entry_type pop_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready
);
   import dbc_pkg::*;

   localparam int PTR_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_WIDTH = $clog2(DEPTH + 1);

   dbc_entry_type           slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_WIDTH-1:0]   fill_ff, fill_in;
   logic                    push, pop;

   assign push_ready = (fill_ff != FILL_WIDTH'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      fill_in = fill_ff;
      if (push && !pop)      fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   // fill never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_WIDTH'(DEPTH))
      else $error("queue overfilled");

endmodule

@@ design/dbc_back.sv @@
// ----------------------------------------------------------------------------
// dbc_back
// Display sequencer: takes one classified tick at a time and sends one
// segment item per shown slot, ones first, through an output register.
// ----------------------------------------------------------------------------
module dbc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dbc_pkg::dbc_entry_type pop_entry,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   dbc_rsp_if.source              rsp_ch
);
   import dbc_pkg::*;

   // active-low segment codes for the decimal digits
   function automatic logic [SEGMENT_WIDTH-1:0] seg_code(input logic [3:0] digit);
      logic [SEGMENT_WIDTH-1:0] code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = BLANK_PATTERN;
      endcase
      return code;
   endfunction

   logic                     cur_valid_ff, cur_valid_in;
   dbc_entry_type            cur_ff, cur_in;
   slot_type                 slot_ff, slot_in;

   logic                     out_valid_ff, out_valid_in;
   slot_type                 out_select_ff, out_select_in;
   logic [SEGMENT_WIDTH-1:0] out_pattern_ff, out_pattern_in;
   logic [COUNT_WIDTH-1:0]   out_count_ff, out_count_in;
   logic                     out_last_ff, out_last_in;

   logic                     out_free, step, is_last, pop;
   logic [SEGMENT_WIDTH-1:0] pattern;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign step      = cur_valid_ff && out_free;
   assign is_last   = (slot_ff == cur_ff.shown - 3'd1);
   assign pop_ready = !cur_valid_ff || (step && is_last);
   assign pop       = pop_valid && pop_ready;

   // pattern of the slot being sent
   always_comb begin
      case (slot_ff)
         SLOT_ONES:      pattern = seg_code(cur_ff.ones);
         SLOT_TENS:      pattern = seg_code(cur_ff.tens);
         SLOT_COLON:     pattern = BLANK_PATTERN;
         SLOT_HUNDREDS:  pattern = seg_code(cur_ff.hundreds);
         SLOT_THOUSANDS: pattern = seg_code({3'd0, cur_ff.thousands});
         default:        pattern = BLANK_PATTERN;
      endcase
   end

   // current tick and slot walk
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = pop_entry;
         slot_in      = SLOT_ONES;
      end else if (step && is_last) begin
         cur_valid_in = 1'b0;
      end else if (step) begin
         slot_in = slot_ff + 3'd1;
      end
   end

   // output register
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_select_in  = out_select_ff;
      out_pattern_in = out_pattern_ff;
      out_count_in   = out_count_ff;
      out_last_in    = out_last_ff;
      if (step) begin
         out_valid_in   = 1'b1;
         out_select_in  = slot_ff;
         out_pattern_in = pattern;
         out_count_in   = cur_ff.count;
         out_last_in    = is_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff         <= cur_in;
      slot_ff        <= slot_in;
      out_select_ff  <= out_select_in;
      out_pattern_ff <= out_pattern_in;
      out_count_ff   <= out_count_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.digit_select    = out_select_ff;
   assign rsp_ch.segment_pattern = out_pattern_ff;
   assign rsp_ch.count_value     = out_count_ff;
   assign rsp_ch.last            = out_last_ff;

   // the slot walk never passes the shown count
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (slot_ff < cur_ff.shown))
      else $error("slot beyond shown count");

   // a new tick is only taken once the previous one has sent its last slot
   assert property (@(posedge clock) disable iff (reset)
      pop && cur_valid_ff |-> step && is_last)
      else $error("tick dropped before its last slot");

endmodule

@@ design/debounced_button_counter_display_top.sv @@
// ----------------------------------------------------------------------------
// debounced_button_counter_display_top
// Debounced pushbutton counter with a multiplexed seven-segment display feed.
// ----------------------------------------------------------------------------
// Usage
//   req_ch carries one scan tick per item: eight active-low button levels.
//   Each press found by the 13-sample debounce adds 2^i to a 10-bit count.
//   rsp_ch returns one item per shown display slot (ones, tens, colon,
//   hundreds, thousands), each with its active-low segment pattern, the
//   count and a last flag on the final slot of the tick; one to five items
//   per tick.
//   Path: a tick passes the front stage register, the tick queue and the
//   current-tick register; its slot items leave the output register.
//   Throughput: a tick can be taken every cycle while the tick queue has
//   room; the display sequencer sends one slot item per cycle while
//   rsp_ch.ready is high and takes the next tick with the last slot item.
//   Reset: histories and count clear, one slot shown, queue and output empty.
//   Stall: when rsp_ch.ready is low the output register holds its item, the
//   tick queue fills and then req_ch.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module debounced_button_counter_display_top #(
   parameter int NUM_BUTTONS = dbc_pkg::NUM_BUTTONS_DEF,
   parameter int QUEUE_DEPTH = dbc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   dbc_req_if.sink  req_ch,
   dbc_rsp_if.source rsp_ch
);
   import dbc_pkg::*;

   dbc_entry_type push_entry, pop_entry;
   logic          push_valid, push_ready;
   logic          pop_valid, pop_ready;

   // debounce, count and digit split
   dbc_front #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // tick buffer
   dbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // slot sequencer
   dbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ verif/debounced_button_counter_display_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debounced_button_counter_display_checker
// Watches the tick and display channels and keeps its own copy of the
// debounce histories, the count and the number of lit slots. Every accepted
// tick queues the slot items it should cause; every accepted display item is
// compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module debounced_button_counter_display_checker #(
   parameter int NUM_BUTTONS = dbc_pkg::NUM_BUTTONS_DEF
) (
   input  logic clock,
   input  logic reset,
   dbc_req_if   req_ch,
   dbc_rsp_if   rsp_ch,
   output int   failures,
   output int   pending
);
   import dbc_pkg::*;

   typedef struct packed {
      slot_type                 digit_select;
      logic [SEGMENT_WIDTH-1:0] segment_pattern;
      logic [COUNT_WIDTH-1:0]   count_value;
      logic                     last;
   } display_slot_type;

   display_slot_type expected_slots[$];
   logic [15:0]      debounce_hist [NUM_BUTTONS];
   int unsigned      press_tally;
   int               slots_lit;
   int               fail_count = 0;

   // active-low segment code of one decimal digit
   function automatic logic [SEGMENT_WIDTH-1:0] seven_seg(input int unsigned digit);
      case (digit)
         0: return 8'hC0;
         1: return 8'hF9;
         2: return 8'hA4;
         3: return 8'hB0;
         4: return 8'h99;
         5: return 8'h92;
         6: return 8'h82;
         7: return 8'hF8;
         8: return 8'h80;
         default: return 8'h90;
      endcase
   endfunction

   // debounce one tick, update the count and queue the slot items it shows
   task automatic queue_tick_slots(input logic [LEVEL_WIDTH-1:0] levels);
      logic [15:0]      hist;
      int unsigned      digit [5];
      display_slot_type slot;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         hist = {debounce_hist[b][14:0], levels[b]} | 16'hE000;
         debounce_hist[b] = hist;
         // a release followed by twelve pressed samples
         if (hist == 16'hF000) begin
            press_tally += (1 << b);
            // wrap takes off 1023, so 1023 itself survives
            if (press_tally > 1023) begin
               press_tally -= 1023;
               slots_lit = 1;
            end
         end
      end

      digit[SLOT_ONES]      = press_tally % 10;
      digit[SLOT_TENS]      = (press_tally / 10) % 10;
      digit[SLOT_COLON]     = 1;  // colon always counts as nonzero
      digit[SLOT_HUNDREDS]  = (press_tally / 100) % 10;
      digit[SLOT_THOUSANDS] = (press_tally / 1000) % 10;

      // at most one more slot per tick, never fewer except on a wrap
      if (slots_lit < SLOT_COUNT && digit[slots_lit] != 0)
         slots_lit++;

      for (int s = 0; s < slots_lit; s++) begin
         slot.digit_select    = slot_type'(s);
         slot.segment_pattern = (s == SLOT_COLON) ? BLANK_PATTERN : seven_seg(digit[s]);
         slot.count_value     = press_tally[COUNT_WIDTH-1:0];
         slot.last            = (s == slots_lit - 1);
         expected_slots.push_back(slot);
      end
   endtask

   // compare one display item with the oldest expectation
   task automatic check_slot(input display_slot_type got);
      display_slot_type want;
      if (expected_slots.size() == 0) begin
         $error("unexpected display item: digit_select %0d segment_pattern %h %s %0d last %0b",
                got.digit_select, got.segment_pattern, "count_value", got.count_value,
                got.last);
         fail_count++;
         return;
      end
      want = expected_slots.pop_front();
      if (got.digit_select !== want.digit_select) begin
         $error("digit_select: expected %0d, actual %0d", want.digit_select, got.digit_select);
         fail_count++;
      end
      if (got.segment_pattern !== want.segment_pattern) begin
         $error("segment_pattern: expected %h, actual %h",
                want.segment_pattern, got.segment_pattern);
         fail_count++;
      end
      if (got.count_value !== want.count_value) begin
         $error("count_value: expected %0d, actual %0d", want.count_value, got.count_value);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, actual %0b", want.last, got.last);
         fail_count++;
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         expected_slots.delete();
         foreach (debounce_hist[b])
            debounce_hist[b] = '0;
         press_tally = 0;
         slots_lit   = 1;
      end else begin
         if (req_ch.valid && req_ch.ready)
            queue_tick_slots(req_ch.button_levels);
         if (rsp_ch.valid && rsp_ch.ready)
            check_slot({rsp_ch.digit_select, rsp_ch.segment_pattern,
                        rsp_ch.count_value, rsp_ch.last});
      end
      failures <= fail_count;
      pending  <= expected_slots.size();
   end

endmodule

@@ verif/debounced_button_counter_display_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debounced_button_counter_display_top_test
// Drives scan ticks into the button counter: a short opening sequence with a
// full eight-button press, then random ticks built mostly from clean
// release-and-hold presses with bounce and noise mixed in. The display side
// stalls at random and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module debounced_button_counter_display_top_test;
   import dbc_pkg::*;

   localparam int RUN_LIMIT       = 100000;
   localparam int RANDOM_TICKS    = 450;
   localparam int DRAIN_CYCLES    = 20;
   localparam int IDLE_PERCENT    = 14;
   localparam int HOLD_OFF_START  = 400;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RSP_QUIET_START = 1000;
   localparam int RSP_QUIET_END   = 1500;
   localparam int REQ_QUIET_START = 150;
   localparam int REQ_QUIET_END   = 250;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   press_hold [NUM_BUTTONS_DEF];
   int   tick_index = 0;
   int   rsp_cycle = 0;

   // opening ticks: pressed from reset, one release, then twelve pressed
   // samples so that all buttons register together, then mixed patterns
   logic [LEVEL_WIDTH-1:0] opening_ticks [24] = '{
      8'h00, 8'h00, 8'hFF,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80, 8'h7F
   };

   dbc_req_if req_ch ();
   dbc_rsp_if rsp_ch ();

   debounced_button_counter_display_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   debounced_button_counter_display_checker slot_check (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .failures (failures),
      .pending  (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // next random scan: per-button clean presses with the odd bounce
   function automatic logic [LEVEL_WIDTH-1:0] next_scan_levels();
      logic [LEVEL_WIDTH-1:0] levels;
      if ($urandom_range(0, 19) == 0)
         return LEVEL_WIDTH'($urandom_range(0, 255));
      for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
         if (press_hold[b] > 0) begin
            levels[b] = ($urandom_range(0, 59) == 0);
            press_hold[b]--;
         end else if ($urandom_range(0, 5) == 0) begin
            // release sample that opens a press, then a hold
            levels[b]     = 1'b1;
            press_hold[b] = $urandom_range(12, 16);
         end else begin
            levels[b] = ($urandom_range(0, 3) != 0);
         end
      end
      return levels;
   endfunction

   // offer one tick, with random gaps outside the quiet stretch
   task automatic send_tick(input logic [LEVEL_WIDTH-1:0] levels);
      bit quiet;
      quiet = (tick_index >= REQ_QUIET_START && tick_index < REQ_QUIET_END);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.button_levels <= levels;
      do @(posedge clock); while (!req_ch.ready);
      tick_index++;
   endtask

   // display side: random stalls, one long hold-off, one stall-free stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (rsp_cycle >= HOLD_OFF_START && rsp_cycle < HOLD_OFF_START + HOLD_OFF_CYCLES)
            rsp_ch.ready <= 1'b0;
         else if (rsp_cycle >= RSP_QUIET_START && rsp_cycle < RSP_QUIET_END)
            rsp_ch.ready <= 1'b1;
         else
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // watchdog
   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // stimulus and verdict
   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.button_levels = '0;
      foreach (press_hold[b])
         press_hold[b] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_ticks[k])
         send_tick(opening_ticks[k]);
      repeat (RANDOM_TICKS)
         send_tick(next_scan_levels());
      req_ch.valid <= 1'b0;

      // drain, then allow for any stray item
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/dbc_pkg.sv
design/dbc_if.sv
design/dbc_front.sv
design/dbc_queue.sv
design/dbc_back.sv
design/debounced_button_counter_display_top.sv
verif/debounced_button_counter_display_checker.sv
verif/debounced_button_counter_display_top_test.sv
